/* rtl/ttpr_pkg.sv */
// Shared types, constants and codes for the transposition table probe/record unit.
`timescale 1ns / 1ps

package ttpr_pkg;

    // Table geometry: the slot is selected by the low key bits.
    localparam int INDEX_BITS = 16;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 64;
    localparam int SCORE_W = 17;
    localparam int DEPTH_W = 8;
    localparam int PLY_W   = 8;
    localparam int FLAG_W  = 2;
    localparam int MOVE_W  = 16;
    localparam int THR_W   = 16;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 40;

    localparam logic [THR_W-1:0] THR_RESET = 16'd48000;

    // Operation selector carried in the input tuser.
    localparam logic OP_PROBE  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // Bound kinds.
    localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_UPPER = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_LOWER = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_MISS   = 2'd0;
    localparam logic [1:0] STAT_SCORE  = 2'd1;
    localparam logic [1:0] STAT_MOVE   = 2'd2;
    localparam logic [1:0] STAT_RECORD = 2'd3;

    // Input tdata layout, lowest field last in the declaration.
    typedef struct packed {
        logic [2:0]                pad;
        logic [MOVE_W-1:0]         store_move;
        logic [FLAG_W-1:0]         store_flag;
        logic signed [SCORE_W-1:0] store_score;
        logic [PLY_W-1:0]          ply_from_root;
        logic [DEPTH_W-1:0]        search_depth;
        logic signed [SCORE_W-1:0] beta_bound;
        logic signed [SCORE_W-1:0] alpha_bound;
        logic [KEY_W-1:0]          position_key;
    } in_item_t;

    // Output tdata layout.
    typedef struct packed {
        logic [6:0]                pad;
        logic [MOVE_W-1:0]         hit_move;
        logic signed [SCORE_W-1:0] result_score;
    } out_item_t;

    // One table slot.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [FLAG_W-1:0]         flag;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic load_item;
        logic mem_rd;
        logic adj_en;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/ttpr_ctrl.sv */
// Controller state machine: clearing pass, item capture, lookup, adjust and decide steps.
`timescale 1ns / 1ps

module ttpr_ctrl
    import ttpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_ADJ   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                cmd.adj_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/ttpr_dpath.sv */
// Datapath: table memory, item registers, mate score adjustment, decision and output register.
`timescale 1ns / 1ps

module ttpr_dpath
    import ttpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   in_op,
    input  logic                   cfg_we,
    input  logic [THR_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic [1:0]             out_status
);

    localparam int WIDE_W = SCORE_W + 2;

    // Two-step mate shift on a 19-bit signed value, then saturation to 17 bits.
    // A record pushes scores outward; a probe pulls them back.
    function automatic logic signed [SCORE_W-1:0] mate_adjust(
        input logic signed [SCORE_W-1:0] s_in,
        input logic [PLY_W-1:0]          ply,
        input logic [THR_W-1:0]          thr,
        input logic                      outward
    );
        logic signed [WIDE_W-1:0] s;
        logic signed [WIDE_W-1:0] thr_w;
        logic signed [WIDE_W-1:0] ply_w;
        logic signed [WIDE_W-1:0] lo_lim;
        logic signed [WIDE_W-1:0] hi_lim;
        s      = WIDE_W'(s_in);
        thr_w  = $signed({{(WIDE_W-THR_W){1'b0}}, thr});
        ply_w  = $signed({{(WIDE_W-PLY_W){1'b0}}, ply});
        lo_lim = $signed(-(WIDE_W'(65536)));
        hi_lim = $signed(WIDE_W'(65535));
        if (s < -thr_w)
        begin
            s = outward ? (s - ply_w) : (s + ply_w);
        end
        if (s > thr_w)
        begin
            s = outward ? (s + ply_w) : (s - ply_w);
        end
        if (s < lo_lim)
        begin
            s = lo_lim;
        end
        else if (s > hi_lim)
        begin
            s = hi_lim;
        end
        return s[SCORE_W-1:0];
    endfunction

    entry_t mem [SLOT_COUNT];

    logic [INDEX_BITS-1:0]      clr_cnt_reg;
    logic [INDEX_BITS-1:0]      clr_cnt_next;
    logic [THR_W-1:0]           thr_reg;
    logic [THR_W-1:0]           thr_next;
    in_item_t                   item_reg;
    logic                       op_reg;
    entry_t                     rd_entry_reg;
    logic signed [SCORE_W-1:0]  adj_score_reg;
    logic                       hit_reg;
    logic                       depth_ok_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 out_status_reg;
    logic signed [SCORE_W-1:0]  out_score_reg;
    logic [MOVE_W-1:0]          out_move_reg;

    logic                       is_record;
    logic                       mem_we;
    logic [INDEX_BITS-1:0]      mem_waddr;
    entry_t                     mem_wdata;
    logic [INDEX_BITS-1:0]      item_slot;
    logic signed [SCORE_W-1:0]  adj_src;
    logic [1:0]                 dec_status;
    logic signed [SCORE_W-1:0]  dec_score;
    logic [MOVE_W-1:0]          dec_move;
    out_item_t                  out_word;

    assign is_record = (op_reg == OP_RECORD);
    assign item_slot = item_reg.position_key[INDEX_BITS-1:0];

    // Status back to the controller.
    assign status.clear_last = (clr_cnt_reg == {INDEX_BITS{1'b1}});
    assign status.out_free   = !out_valid_reg || out_ready;

    // Clearing pass counter and threshold register.
    assign clr_cnt_next = cmd.clear_en ? (clr_cnt_reg + 1'b1) : clr_cnt_reg;
    assign thr_next     = cfg_we ? cfg_data : thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            thr_reg     <= THR_RESET;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            thr_reg     <= thr_next;
        end
    end

    // Table write: zeros during the clearing pass, the new entry on a record.
    always_comb
    begin
        mem_we    = cmd.clear_en || (cmd.finish && is_record);
        mem_waddr = cmd.clear_en ? clr_cnt_reg : item_slot;
        if (cmd.clear_en)
        begin
            mem_wdata = '0;
        end
        else
        begin
            mem_wdata.key   = item_reg.position_key;
            mem_wdata.score = adj_score_reg;
            mem_wdata.flag  = item_reg.store_flag;
            mem_wdata.depth = item_reg.search_depth;
            mem_wdata.move  = item_reg.store_move;
        end
    end

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_entry_reg <= mem[item_slot];
        end
    end

    // Item capture and adjust step.
    assign adj_src = is_record ? item_reg.store_score : rd_entry_reg.score;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item_t'(in_data);
            op_reg   <= in_op;
        end
        if (cmd.adj_en)
        begin
            adj_score_reg <= mate_adjust(adj_src, item_reg.ply_from_root, thr_reg, is_record);
            hit_reg       <= (rd_entry_reg.key == item_reg.position_key);
            depth_ok_reg  <= (rd_entry_reg.depth >= item_reg.search_depth);
        end
    end

    // Decide the result from the adjusted score, the flag and the bounds.
    always_comb
    begin
        dec_status = STAT_MOVE;
        dec_score  = '0;
        dec_move   = rd_entry_reg.move;
        if (is_record)
        begin
            dec_status = STAT_RECORD;
            dec_move   = '0;
        end
        else if (!hit_reg)
        begin
            dec_status = STAT_MISS;
            dec_move   = '0;
        end
        else if (depth_ok_reg)
        begin
            if (rd_entry_reg.flag == FLAG_EXACT)
            begin
                dec_status = STAT_SCORE;
                dec_score  = adj_score_reg;
                dec_move   = '0;
            end
            else if (rd_entry_reg.flag == FLAG_UPPER && adj_score_reg <= item_reg.alpha_bound)
            begin
                dec_status = STAT_SCORE;
                dec_score  = item_reg.alpha_bound;
                dec_move   = '0;
            end
            else if (rd_entry_reg.flag == FLAG_LOWER && adj_score_reg >= item_reg.beta_bound)
            begin
                dec_status = STAT_SCORE;
                dec_score  = item_reg.beta_bound;
                dec_move   = '0;
            end
        end
    end

    // Output register: holds one result until the downstream side takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= dec_status;
            out_score_reg  <= dec_score;
            out_move_reg   <= dec_move;
        end
    end

    always_comb
    begin
        out_word.pad          = '0;
        out_word.hit_move     = out_move_reg;
        out_word.result_score = out_score_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_word;
    assign out_status = out_status_reg;

endmodule

/* rtl/transposition_table_probe_record_unit.sv */
// Top level of the direct-mapped transposition table probe/record unit.
//
//   Channel   Direction  Transfer condition         Contents
//   s_axis    in         s_axis_tvalid & tready     one probe or record request
//   m_axis    out        m_axis_tvalid & tready     one result per request
//   cfg       in         cfg_valid & cfg_ready      mate threshold
//
// Each request steps through capture, table read, mate adjustment, and decision with
// table write; the next request is taken only after the decision step is done.
// The table read is registered, and the mate adjustment has its own step.
// After reset a clearing pass writes zeros to all 2^INDEX_BITS slots
// while s_axis_tready stays low; configuration writes are taken throughout.
// A finished result waits in the output register while the next request is taken;
// the decision step holds until that register is free.
`timescale 1ns / 1ps

module transposition_table_probe_record_unit
    import ttpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // position_key[63:0], alpha_bound[80:64], beta_bound[97:81], search_depth[105:98],
    // ply_from_root[113:106], store_score[130:114], store_flag[132:131],
    // store_move[148:133], zero fill [151:149]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                   s_axis_tuser,
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_score[16:0], hit_move[32:17], zero fill [39:33]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]             m_axis_tuser,
    // Configuration write.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [THR_W-1:0]       cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // The threshold register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    ttpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    ttpr_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (dp_status),
        .in_data    (s_axis_tdata),
        .in_op      (s_axis_tuser),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule
